// File: src/u8d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 decoder package
// Types and constants shared by the decode step and the top level.
// ----------------------------------------------------------------------------
package u8d_pkg;

   // Length of the multi-byte sequence that is being gathered.
   localparam logic [2:0] SEQ_NONE = 3'd0;
   localparam logic [2:0] SEQ_LEN2 = 3'd2;
   localparam logic [2:0] SEQ_LEN3 = 3'd3;
   localparam logic [2:0] SEQ_LEN4 = 3'd4;

   // Smallest scalar value that each sequence length may legally carry.
   localparam logic [20:0] MIN_LEN2 = 21'h00080;
   localparam logic [20:0] MIN_LEN3 = 21'h00800;
   localparam logic [20:0] MIN_LEN4 = 21'h10000;

   // Upper end of the Unicode range and the surrogate block.
   localparam logic [20:0] CP_MAX        = 21'h10FFFF;
   localparam logic [20:0] SURROGATE_LO  = 21'h00D800;
   localparam logic [20:0] SURROGATE_HI  = 21'h00DFFF;

   localparam logic [15:0] STORE_LIMIT_RESET = 16'd512;

   // Pending sequence held between bytes.
   typedef struct packed {
      logic [20:0] partial_value;
      logic [2:0]  sequence_length;
      logic [1:0]  bytes_taken;
   } dec_state_type;

   // One result as it leaves the block.
   typedef struct packed {
      logic        has_codepoint;
      logic [20:0] codepoint;
      logic [15:0] codepoint_index;
      logic        string_done;
      logic [15:0] total_codepoints;
      logic [15:0] bad_bytes;
   } result_type;

endpackage

// File: src/u8d_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 decode step
// Combinational next-state and result logic for one byte of the stream.
// ----------------------------------------------------------------------------
module u8d_step #(
   parameter int COUNT_BITS = 16
) (
   input  logic [7:0]              text_byte,
   input  u8d_pkg::dec_state_type  dec_cur,
   input  logic [COUNT_BITS-1:0]   cp_count,
   input  logic [COUNT_BITS-1:0]   bad_count,
   input  logic [15:0]             store_limit,
   output u8d_pkg::dec_state_type  dec_nxt,
   output logic [COUNT_BITS-1:0]   cp_count_nxt,
   output logic [COUNT_BITS-1:0]   bad_count_nxt,
   output logic                    res_valid,
   output u8d_pkg::result_type     result
);
   import u8d_pkg::*;

   localparam int CMP_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;

   logic        is_zero;
   logic        is_cont;
   logic        ascii;
   logic        lead_bad;
   logic [2:0]  lead_len;
   logic [20:0] lead_bits;
   logic [20:0] new_partial;
   logic [2:0]  taken_inc;
   logic [20:0] min_value;
   logic        value_ok;
   logic [2:0]  bad_k;
   logic        cp_take;
   logic [20:0] cp_value;
   logic        index_ok;
   logic [COUNT_BITS-1:0] bad_sum;

   // Adds a small amount to a counter, holding at all ones.
   function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] c,
                                                     input logic [2:0] k);
      logic [COUNT_BITS:0] s;
      s = {1'b0, c} + {{(COUNT_BITS - 2){1'b0}}, k};
      return s[COUNT_BITS] ? '1 : s[COUNT_BITS-1:0];
   endfunction

   assign is_zero     = (text_byte == 8'h00);
   assign is_cont     = (text_byte[7:6] == 2'b10);
   assign new_partial = {dec_cur.partial_value[14:0], text_byte[5:0]};
   assign taken_inc   = {1'b0, dec_cur.bytes_taken} + 3'd1;

   // Classify the byte as a lead byte.
   always_comb begin
      ascii     = 1'b0;
      lead_bad  = 1'b0;
      lead_len  = SEQ_NONE;
      lead_bits = '0;
      case (text_byte) inside
         [8'h01:8'h7F]: begin
            ascii = 1'b1;
         end
         [8'hC0:8'hDF]: begin
            lead_len  = SEQ_LEN2;
            lead_bits = {16'd0, text_byte[4:0]};
         end
         [8'hE0:8'hEF]: begin
            lead_len  = SEQ_LEN3;
            lead_bits = {17'd0, text_byte[3:0]};
         end
         [8'hF0:8'hF7]: begin
            lead_len  = SEQ_LEN4;
            lead_bits = {18'd0, text_byte[2:0]};
         end
         default: begin
            lead_bad = 1'b1;
         end
      endcase
   end

   // Legal range check for a completed sequence.
   always_comb begin
      case (dec_cur.sequence_length)
         SEQ_LEN2: min_value = MIN_LEN2;
         SEQ_LEN3: min_value = MIN_LEN3;
         default:  min_value = MIN_LEN4;
      endcase
   end

   assign value_ok = (new_partial >= min_value) && (new_partial <= CP_MAX) &&
                     !((new_partial >= SURROGATE_LO) && (new_partial <= SURROGATE_HI));

   // Sequence tracking: start, continue, complete or abandon a sequence.
   always_comb begin
      dec_nxt  = dec_cur;
      bad_k    = 3'd0;
      cp_take  = 1'b0;
      cp_value = '0;
      if (is_zero) begin
         dec_nxt = '0;
         if (dec_cur.sequence_length != SEQ_NONE) begin
            bad_k = {1'b0, dec_cur.bytes_taken};
         end
      end else if ((dec_cur.sequence_length == SEQ_NONE) || !is_cont) begin
         // Held bytes of a broken sequence are bad; the byte starts afresh.
         dec_nxt = '0;
         if (dec_cur.sequence_length != SEQ_NONE) begin
            bad_k = {1'b0, dec_cur.bytes_taken};
         end
         if (ascii) begin
            cp_take  = 1'b1;
            cp_value = {13'd0, text_byte};
         end else if (lead_bad) begin
            bad_k = bad_k + 3'd1;
         end else begin
            dec_nxt.partial_value   = lead_bits;
            dec_nxt.sequence_length = lead_len;
            dec_nxt.bytes_taken     = 2'd1;
         end
      end else if (taken_inc < dec_cur.sequence_length) begin
         dec_nxt.partial_value = new_partial;
         dec_nxt.bytes_taken   = taken_inc[1:0];
      end else begin
         dec_nxt = '0;
         if (value_ok) begin
            cp_take  = 1'b1;
            cp_value = new_partial;
         end else begin
            bad_k = dec_cur.sequence_length;
         end
      end
   end

   assign bad_sum  = sat_add(bad_count, bad_k);
   assign index_ok = CMP_W'(cp_count) < CMP_W'(store_limit);

   // Counters and the result item.
   always_comb begin
      res_valid     = 1'b0;
      result        = '0;
      bad_count_nxt = bad_sum;
      cp_count_nxt  = cp_take ? sat_add(cp_count, 3'd1) : cp_count;
      if (is_zero) begin
         res_valid               = 1'b1;
         result.string_done      = 1'b1;
         result.total_codepoints = 16'(cp_count);
         result.bad_bytes        = 16'(bad_sum);
         bad_count_nxt           = '0;
         cp_count_nxt            = '0;
      end else if (cp_take && index_ok) begin
         res_valid              = 1'b1;
         result.has_codepoint   = 1'b1;
         result.codepoint       = cp_value;
         result.codepoint_index = 16'(cp_count);
      end
   end

endmodule

// File: src/utf8_validating_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 validating decoder
// Decodes a zero-terminated UTF-8 byte stream, one byte per request, giving
// one response per stored code point and a summary response at the end.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Ports                              Carries
//  req       in         req_valid, req_stall, req_text_byte  one raw byte
//  rsp       out        rsp_valid, rsp_stall, rsp_*            code point or summary
//  csr       in         csr_write_enable, csr_write_data       store_limit
//
//  One byte is accepted in every cycle in which req_stall is low; the decode
//  of a byte is a single pass of logic between the state registers and the
//  response register, or the skid register while the output is stalled.
//  A skid register behind the response register takes one response while
//  the output is stalled; req_stall rises only while the skid register is full.
//  Reset is synchronous and clears the decode state, the counters and
//  store_limit (to 512); no clearing pass is needed.
//
module utf8_validating_decoder #(
   parameter int COUNT_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // Byte requests
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_text_byte,
   // Responses
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_has_codepoint,
   output logic [20:0] rsp_codepoint,
   output logic [15:0] rsp_codepoint_index,
   output logic        rsp_string_done,
   output logic [15:0] rsp_total_codepoints,
   output logic [15:0] rsp_bad_bytes,
   // Configuration
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data
);
   import u8d_pkg::*;

   dec_state_type         dec_ff, dec_in;
   logic [COUNT_BITS-1:0] cp_count_ff, cp_count_in;
   logic [COUNT_BITS-1:0] bad_count_ff, bad_count_in;
   logic [15:0]           store_limit_ff;

   logic                  out_valid_ff, out_valid_in;
   result_type            out_ff, out_in;
   logic                  skid_valid_ff, skid_valid_in;
   result_type            skid_ff, skid_in;

   logic                  accept_in;
   logic                  out_take;
   logic                  step_valid;
   result_type            step_result;
   logic                  res_valid;

   assign req_stall = skid_valid_ff;
   assign accept_in = req_valid && !req_stall;
   assign out_take  = out_valid_ff && !rsp_stall;
   assign res_valid = accept_in && step_valid;

   // Per-byte decode logic.
   u8d_step #(
      .COUNT_BITS (COUNT_BITS)
   ) u_step (
      .text_byte     (req_text_byte),
      .dec_cur       (dec_ff),
      .cp_count      (cp_count_ff),
      .bad_count     (bad_count_ff),
      .store_limit   (store_limit_ff),
      .dec_nxt       (dec_in),
      .cp_count_nxt  (cp_count_in),
      .bad_count_nxt (bad_count_in),
      .res_valid     (step_valid),
      .result        (step_result)
   );

   // Decode state and counters advance on every accepted request.
   always_ff @(posedge clock) begin
      if (reset) begin
         dec_ff       <= '0;
         cp_count_ff  <= '0;
         bad_count_ff <= '0;
      end else if (accept_in) begin
         dec_ff       <= dec_in;
         cp_count_ff  <= cp_count_in;
         bad_count_ff <= bad_count_in;
      end
   end

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         store_limit_ff <= STORE_LIMIT_RESET;
      end else if (csr_write_enable) begin
         store_limit_ff <= csr_write_data;
      end
   end

   // Response register and skid register steering.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (!out_valid_ff || out_take) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = res_valid;
            out_in       = step_result;
         end
      end else if (res_valid) begin
         skid_valid_in = 1'b1;
         skid_in       = step_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_has_codepoint    = out_ff.has_codepoint;
   assign rsp_codepoint        = out_ff.codepoint;
   assign rsp_codepoint_index  = out_ff.codepoint_index;
   assign rsp_string_done      = out_ff.string_done;
   assign rsp_total_codepoints = out_ff.total_codepoints;
   assign rsp_bad_bytes        = out_ff.bad_bytes;

`ifndef SYNTHESIS
   // The skid register only fills behind a full response register.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register full while response register is empty");

   // A pending sequence always holds at least one byte and fewer than its length.
   a_pending_shape: assert property (@(posedge clock) disable iff (reset)
      (dec_ff.sequence_length != SEQ_NONE) |->
         ((dec_ff.bytes_taken != 2'd0) &&
          ({1'b0, dec_ff.bytes_taken} < dec_ff.sequence_length)))
      else $error("pending sequence state is inconsistent");

   // The terminating zero byte clears the decode state and both counters.
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (accept_in && (req_text_byte == 8'h00)) |=>
         ((dec_ff == '0) && (cp_count_ff == '0) && (bad_count_ff == '0)))
      else $error("state not cleared after end of string");

   // A summary response never carries a code point.
   a_done_exclusive: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.string_done) |->
         (!out_ff.has_codepoint && (out_ff.codepoint == '0)))
      else $error("summary response carries a code point");
`endif

endmodule
